// ===== design/rotate_point_about_center_unit_macros.svh =====
// Assertion macros shared by the rotation unit.
`ifndef ROTATE_POINT_ABOUT_CENTER_UNIT_MACROS_SVH
`define ROTATE_POINT_ABOUT_CENTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rotate_point_about_center_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rotate_point_about_center_unit: next-cycle check failed");

`endif

// ===== design/rpc_pkg.sv =====
// Package of the rotation unit: defaults, CORDIC constants, quadrant codes and types.
package rpc_pkg;

	// Default configuration of the unit.
	localparam int COORD_WIDTH_DEF    = 24;
	localparam int ANGLE_WIDTH_DEF    = 16;
	localparam int ROTATION_STEPS_DEF = 16;
	localparam int MAX_STEPS          = 32;

	// Start vector length: the inverse CORDIC gain in Q30.
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	// Quarter turn picked by the top angle bits.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Arctangent of 2^-i in units of 2^32 per turn.
	localparam logic signed [31:0] ATAN_TURN [MAX_STEPS] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
		32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
		32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
		32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
		32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
		32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
		32'sh00000003, 32'sh00000001, 32'sh00000001, 32'sh00000000
	};

	// CORDIC working vector and residual angle.
	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic signed [31:0] z;
	} rpc_cordic_t;

endpackage

// ===== design/rpc_point_if.sv =====
// Input channel of the rotation unit: point, centre and angle.
interface rpc_point_if #(
	parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = rpc_pkg::ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic        [ANGLE_WIDTH-1:0] turn_angle;

	modport source (
		output valid, point_x, point_y, center_x, center_y, turn_angle,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, center_x, center_y, turn_angle,
		output ready
	);
endinterface

// ===== design/rpc_result_if.sv =====
// Output channel of the rotation unit: rotated point and saturation flag.
interface rpc_result_if #(
	parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rotated_x;
	logic signed [COORD_WIDTH-1:0] rotated_y;
	logic                          clipped;

	modport source (
		output valid, rotated_x, rotated_y, clipped,
		input  ready
	);
	modport sink (
		input  valid, rotated_x, rotated_y, clipped,
		output ready
	);
endinterface

// ===== design/rpc_cordic_step.sv =====
// One registered micro-rotation of the rotation-mode CORDIC chain.
module rpc_cordic_step #(
	parameter int SIDE_W = 8,
	parameter int STEP   = 0
) (
	input  logic                clk,
	input  logic                en,
	input  rpc_pkg::rpc_cordic_t cor_in,
	input  logic [SIDE_W-1:0]   side_in,
	output rpc_pkg::rpc_cordic_t cor_s1,
	output logic [SIDE_W-1:0]   side_s1
);
	import rpc_pkg::*;

	localparam logic [4:0] STEP_IDX = 5'(STEP);
	localparam logic signed [31:0] ANGLE_STEP = ATAN_TURN[STEP_IDX];

	logic signed [31:0] c_cur;
	logic signed [31:0] s_cur;
	logic signed [31:0] c_sh;
	logic signed [31:0] s_sh;
	rpc_cordic_t        cor_nxt;

	// Rotate towards a zero residual angle by arctan(2^-STEP).
	always_comb begin
		c_cur = cor_in.c;
		s_cur = cor_in.s;
		c_sh  = c_cur >>> STEP;
		s_sh  = s_cur >>> STEP;
		if (!cor_in.z[31]) begin
			cor_nxt.c = c_cur - s_sh;
			cor_nxt.s = s_cur + c_sh;
			cor_nxt.z = cor_in.z - ANGLE_STEP;
		end else begin
			cor_nxt.c = c_cur + s_sh;
			cor_nxt.s = s_cur - c_sh;
			cor_nxt.z = cor_in.z + ANGLE_STEP;
		end
	end

	// Stage register; the side payload rides along unchanged.
	always_ff @(posedge clk) begin
		if (en) begin
			cor_s1  <= cor_nxt;
			side_s1 <= side_in;
		end
	end
endmodule

// ===== design/rpc_quad_map.sv =====
// Registered quarter-turn correction that turns the CORDIC vector into rotation coefficients.
module rpc_quad_map #(
	parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  rpc_pkg::rpc_cordic_t          cor,
	input  logic [1:0]                    quad,
	input  logic signed [COORD_WIDTH:0]   off_x,
	input  logic signed [COORD_WIDTH:0]   off_y,
	input  logic signed [COORD_WIDTH-1:0] ctr_x,
	input  logic signed [COORD_WIDTH-1:0] ctr_y,
	output logic signed [31:0]            x_coef_a_s1,
	output logic signed [31:0]            x_coef_b_s1,
	output logic signed [31:0]            y_coef_a_s1,
	output logic signed [31:0]            y_coef_b_s1,
	output logic signed [COORD_WIDTH:0]   off_x_s1,
	output logic signed [COORD_WIDTH:0]   off_y_s1,
	output logic signed [COORD_WIDTH-1:0] ctr_x_s1,
	output logic signed [COORD_WIDTH-1:0] ctr_y_s1
);
	import rpc_pkg::*;

	logic signed [31:0] cos_v;
	logic signed [31:0] sin_v;
	logic signed [31:0] nsin_v;

	// Apply the quarter turn exactly by swapping and negating.
	always_comb begin
		unique case (quad)
			QUAD_0: begin
				cos_v  = cor.c;
				sin_v  = cor.s;
				nsin_v = -cor.s;
			end
			QUAD_1: begin
				cos_v  = -cor.s;
				sin_v  = cor.c;
				nsin_v = -cor.c;
			end
			QUAD_2: begin
				cos_v  = -cor.c;
				sin_v  = -cor.s;
				nsin_v = cor.s;
			end
			default: begin
				cos_v  = cor.s;
				sin_v  = -cor.c;
				nsin_v = cor.c;
			end
		endcase
	end

	// x' = dx*cos + dy*(-sin), y' = dx*sin + dy*cos.
	always_ff @(posedge clk) begin
		if (en) begin
			x_coef_a_s1 <= cos_v;
			x_coef_b_s1 <= nsin_v;
			y_coef_a_s1 <= sin_v;
			y_coef_b_s1 <= cos_v;
			off_x_s1    <= off_x;
			off_y_s1    <= off_y;
			ctr_x_s1    <= ctr_x;
			ctr_y_s1    <= ctr_y;
		end
	end
endmodule

// ===== design/rpc_rotate_term.sv =====
// Four-stage unit for round(a*ca + b*cb over 2^30) plus centre, saturated to the coordinate range.
module rpc_rotate_term #(
	parameter int COORD_WIDTH = rpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic [3:0]                    en,
	input  logic signed [COORD_WIDTH:0]   off_a,
	input  logic signed [COORD_WIDTH:0]   off_b,
	input  logic signed [31:0]            coef_a,
	input  logic signed [31:0]            coef_b,
	input  logic signed [COORD_WIDTH-1:0] ctr,
	output logic signed [COORD_WIDTH-1:0] res_s4,
	output logic                          hit_s4
);
	localparam int OFF_W = COORD_WIDTH + 1;
	localparam int LO_W  = 16;
	localparam int EXT_W = (OFF_W > LO_W) ? OFF_W : LO_W + 1;
	localparam int HI_W  = EXT_W - LO_W;
	localparam int PH_W  = HI_W + 32;
	localparam int PL_W  = LO_W + 1 + 32;
	localparam int HS_W  = PH_W + 1;
	localparam int LS_W  = PL_W + 2;
	localparam int SUM_W = (((HS_W + LO_W) > LS_W) ? (HS_W + LO_W) : LS_W) + 1;
	localparam int ROT_W = SUM_W - 30;
	localparam int RES_W = ROT_W + 1;

	// Half of 2^30, for round to nearest with ties upwards.
	localparam logic signed [LS_W-1:0] ROUND_BIAS = {{(LS_W - 30){1'b0}}, 1'b1, 29'd0};

	logic signed [EXT_W-1:0]   a_ext;
	logic signed [EXT_W-1:0]   b_ext;
	logic signed [HI_W-1:0]    a_hi;
	logic signed [HI_W-1:0]    b_hi;
	logic signed [LO_W:0]      a_lo;
	logic signed [LO_W:0]      b_lo;
	logic signed [PH_W-1:0]    p_ah_s1;
	logic signed [PH_W-1:0]    p_bh_s1;
	logic signed [PL_W-1:0]    p_al_s1;
	logic signed [PL_W-1:0]    p_bl_s1;
	logic signed [COORD_WIDTH-1:0] ctr_s1;
	logic signed [HS_W-1:0]    hs_s2;
	logic signed [LS_W-1:0]    ls_s2;
	logic signed [COORD_WIDTH-1:0] ctr_s2;
	logic signed [SUM_W-1:0]   total;
	logic signed [ROT_W-1:0]   rot_s3;
	logic signed [COORD_WIDTH-1:0] ctr_s3;
	logic signed [RES_W-1:0]   sum;
	logic [RES_W-COORD_WIDTH:0] sum_top;

	// Split each offset into a signed high part and an unsigned 16-bit low part.
	always_comb begin
		a_ext = EXT_W'(off_a);
		b_ext = EXT_W'(off_b);
		a_hi  = a_ext[EXT_W-1:LO_W];
		b_hi  = b_ext[EXT_W-1:LO_W];
		a_lo  = {1'b0, a_ext[LO_W-1:0]};
		b_lo  = {1'b0, b_ext[LO_W-1:0]};
	end

	// Stage 1: four partial products.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_ah_s1 <= PH_W'(a_hi) * PH_W'(coef_a);
			p_bh_s1 <= PH_W'(b_hi) * PH_W'(coef_b);
			p_al_s1 <= PL_W'(a_lo) * PL_W'(coef_a);
			p_bl_s1 <= PL_W'(b_lo) * PL_W'(coef_b);
			ctr_s1  <= ctr;
		end
	end

	// Stage 2: sum the high and the low partial products, adding the rounding bias.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			hs_s2  <= HS_W'(p_ah_s1) + HS_W'(p_bh_s1);
			ls_s2  <= LS_W'(p_al_s1) + LS_W'(p_bl_s1) + ROUND_BIAS;
			ctr_s2 <= ctr_s1;
		end
	end

	// Stage 3: recombine and take the floor of the quotient by 2^30.
	assign total = (SUM_W'(hs_s2) <<< LO_W) + SUM_W'(ls_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rot_s3 <= total[SUM_W-1:30];
			ctr_s3 <= ctr_s2;
		end
	end

	// Stage 4: add the centre back and saturate.
	assign sum     = RES_W'(rot_s3) + RES_W'(ctr_s3);
	assign sum_top = sum[RES_W-1:COORD_WIDTH-1];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			if ((&sum_top) || !(|sum_top)) begin
				res_s4 <= sum[COORD_WIDTH-1:0];
				hit_s4 <= 1'b0;
			end else if (sum[RES_W-1]) begin
				res_s4 <= {1'b1, {(COORD_WIDTH - 1){1'b0}}};
				hit_s4 <= 1'b1;
			end else begin
				res_s4 <= {1'b0, {(COORD_WIDTH - 1){1'b1}}};
				hit_s4 <= 1'b1;
			end
		end
	end
endmodule

// ===== design/rotate_point_about_center_unit.sv =====
// Top level of the pipelined rotation of a point about a centre.
//
//   Channel   Direction   Payload
//   points    in          point_x, point_y, center_x, center_y, turn_angle
//   rotated   out         rotated_x, rotated_y, clipped
//
// One transaction is accepted every cycle while the output is taken or a bubble remains.
// The CORDIC chain gives each micro-rotation its own stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// An output stall holds only the full stages behind it; empty stages keep filling,
// so points stays ready while any bubble remains in the pipeline.
`include "rotate_point_about_center_unit_macros.svh"

module rotate_point_about_center_unit #(
	parameter int COORD_WIDTH    = rpc_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH    = rpc_pkg::ANGLE_WIDTH_DEF,
	parameter int ROTATION_STEPS = rpc_pkg::ROTATION_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rpc_point_if.sink     points,
	rpc_result_if.source  rotated
);
	import rpc_pkg::*;

	localparam int OFF_W = COORD_WIDTH + 1;
	localparam int DEPTH = ROTATION_STEPS + 6;
	localparam int MAP_STAGE  = ROTATION_STEPS + 1;
	localparam int TERM_STAGE = ROTATION_STEPS + 2;

	// Values carried alongside the CORDIC vector.
	typedef struct packed {
		logic [1:0]                    quad;
		logic signed [OFF_W-1:0]       dx;
		logic signed [OFF_W-1:0]       dy;
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	logic [DEPTH-1:0]   stage_valid_q;
	logic [DEPTH-1:0]   valid_in;
	logic [DEPTH:0]     stage_en;
	logic [31:0]        z32;
	side_t              in_side;
	rpc_cordic_t        in_cor;
	side_t              side_s1;
	rpc_cordic_t        cor_s1;
	rpc_cordic_t        cor_chain  [ROTATION_STEPS+1];
	logic [SIDE_W-1:0]  side_chain [ROTATION_STEPS+1];
	side_t              side_last;
	logic signed [31:0] x_coef_a;
	logic signed [31:0] x_coef_b;
	logic signed [31:0] y_coef_a;
	logic signed [31:0] y_coef_b;
	logic signed [OFF_W-1:0]       map_dx;
	logic signed [OFF_W-1:0]       map_dy;
	logic signed [COORD_WIDTH-1:0] map_cx;
	logic signed [COORD_WIDTH-1:0] map_cy;
	logic                          hit_x;
	logic                          hit_y;

	// A stage may load when the output is taken or a bubble lies at or after it.
	assign stage_en[DEPTH] = rotated.ready;
	for (genvar k = 0; k < DEPTH; k++) begin : g_en
		assign stage_en[k] = stage_en[DEPTH] || !(&stage_valid_q[DEPTH-1:k]);
	end

	assign valid_in = {stage_valid_q[DEPTH-2:0], points.valid};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int k = 0; k < DEPTH; k++) begin
				if (stage_en[k]) begin
					stage_valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	assign points.ready  = stage_en[0];
	assign rotated.valid = stage_valid_q[DEPTH-1];

	// Input stage: offset from the centre, quadrant and residual angle in [-1/8, 1/8) turn.
	always_comb begin
		z32          = 32'(points.turn_angle) << (32 - ANGLE_WIDTH);
		in_side.quad = z32[31:30] + {1'b0, z32[29]};
		in_side.dx   = OFF_W'(points.point_x) - OFF_W'(points.center_x);
		in_side.dy   = OFF_W'(points.point_y) - OFF_W'(points.center_y);
		in_side.cx   = points.center_x;
		in_side.cy   = points.center_y;
		in_cor.c     = CORDIC_GAIN;
		in_cor.s     = '0;
		in_cor.z     = 32'($signed(z32[29:0]));
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			side_s1 <= in_side;
			cor_s1  <= in_cor;
		end
	end

	assign cor_chain[0]  = cor_s1;
	assign side_chain[0] = SIDE_W'(side_s1);

	// CORDIC chain, one micro-rotation per stage.
	for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_step
		rpc_cordic_step #(
			.SIDE_W (SIDE_W),
			.STEP   (k)
		) u_step (
			.clk     (clk),
			.en      (stage_en[k+1]),
			.cor_in  (cor_chain[k]),
			.side_in (side_chain[k]),
			.cor_s1  (cor_chain[k+1]),
			.side_s1 (side_chain[k+1])
		);
	end

	assign side_last = side_t'(side_chain[ROTATION_STEPS]);

	// Quarter-turn correction into rotation coefficients.
	rpc_quad_map #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_map (
		.clk         (clk),
		.en          (stage_en[MAP_STAGE]),
		.cor         (cor_chain[ROTATION_STEPS]),
		.quad        (side_last.quad),
		.off_x       (side_last.dx),
		.off_y       (side_last.dy),
		.ctr_x       (side_last.cx),
		.ctr_y       (side_last.cy),
		.x_coef_a_s1 (x_coef_a),
		.x_coef_b_s1 (x_coef_b),
		.y_coef_a_s1 (y_coef_a),
		.y_coef_b_s1 (y_coef_b),
		.off_x_s1    (map_dx),
		.off_y_s1    (map_dy),
		.ctr_x_s1    (map_cx),
		.ctr_y_s1    (map_cy)
	);

	// Rotated x and y, each with its own multiply, round and saturate pipeline.
	rpc_rotate_term #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_term_x (
		.clk    (clk),
		.en     (stage_en[TERM_STAGE+3:TERM_STAGE]),
		.off_a  (map_dx),
		.off_b  (map_dy),
		.coef_a (x_coef_a),
		.coef_b (x_coef_b),
		.ctr    (map_cx),
		.res_s4 (rotated.rotated_x),
		.hit_s4 (hit_x)
	);

	rpc_rotate_term #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_term_y (
		.clk    (clk),
		.en     (stage_en[TERM_STAGE+3:TERM_STAGE]),
		.off_a  (map_dx),
		.off_b  (map_dy),
		.coef_a (y_coef_a),
		.coef_b (y_coef_b),
		.ctr    (map_cy),
		.res_s4 (rotated.rotated_y),
		.hit_s4 (hit_y)
	);

	assign rotated.clipped = hit_x || hit_y;

	// A full pipeline behind a stalled output takes no new transaction.
	`RPC_ASSERT_NOW(a_full_stall_blocks, clk, arst_n, rotated.valid && !rotated.ready && (&stage_valid_q), !points.ready)
	// An accepted transaction lands in the input stage.
	`RPC_ASSERT_NEXT(a_accept_lands, clk, arst_n, points.valid && points.ready, stage_valid_q[0])
	// A transaction in front of a bubble always moves on.
	`RPC_ASSERT_NEXT(a_bubble_filled, clk, arst_n, stage_valid_q[0] && !stage_valid_q[1], stage_valid_q[1])
endmodule
